// File: rtl/itoa_pkg.sv
package itoa_pkg;

  // Width of the integer being converted.
  localparam int VALUE_BITS = 32;
  // Radix field width and ASCII character width.
  localparam int RADIX_W = 6;
  localparam int CHAR_W = 7;
  // Digit buffer addressing: one entry per possible digit.
  localparam int IDX_W = $clog2(VALUE_BITS);
  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  // Divide step counter.
  localparam int STEP_W = $clog2(VALUE_BITS);

  localparam logic [RADIX_W-1:0] RADIX_MIN     = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX     = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] DEC_RADIX     = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] MAX_DEC_DIGIT = RADIX_W'(9);

  localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] CH_A     = CHAR_W'(8'h61);
  localparam logic [CHAR_W-1:0] CH_MINUS = CHAR_W'(8'h2D);

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]           radix;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last_char;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic quo_zero;
    logic minus;
    logic out_free;
    logic last_digit;
  } stat_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_STORE = 5'b00100,
    S_SIGN  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  // Maps a digit value 0 to 35 onto '0'-'9' and 'a'-'z'.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [RADIX_W-1:0] above;
    above = d - DEC_RADIX;
    if (d > MAX_DEC_DIGIT) begin
      return CHAR_W'(above) + CH_A;
    end
    return CHAR_W'(d) + CH_ZERO;
  endfunction

endpackage

// File: rtl/itoa_ctrl.sv
module itoa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  itoa_pkg::stat_t   stat,
  output itoa_pkg::cmd_t    cmd
);
  import itoa_pkg::*;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(VALUE_BITS - 1)) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        step_nxt  = '0;
        if (stat.quo_zero) begin
          state_nxt = stat.minus ? S_SIGN : S_EMIT;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_SIGN: begin
        if (stat.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_digit = 1'b1;
          if (stat.last_digit) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// File: rtl/itoa_dp.sv
module itoa_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  itoa_pkg::in_t    in_data,
  input  itoa_pkg::cmd_t   cmd,
  output itoa_pkg::stat_t  stat,
  output logic             out_valid,
  input  logic             out_stall,
  output itoa_pkg::out_t   out_data
);
  import itoa_pkg::*;

  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [RADIX_W-1:0]    rem_r, rem_nxt;
  logic [RADIX_W-1:0]    radix_r;
  logic                  minus_r;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_r;
  logic [CHAR_W-1:0]     dig_mem [VALUE_BITS];

  logic [RADIX_W-1:0]    radix_cl;
  logic [VALUE_BITS-1:0] in_bits;
  logic                  neg_dec;
  logic [VALUE_BITS-1:0] mag;
  logic [RADIX_W:0]      rem_sh;
  logic [RADIX_W:0]      rem_diff;
  logic                  rem_ge;
  logic [CNT_W-1:0]      cnt_m1;
  logic [IDX_W-1:0]      rd_idx;
  logic [IDX_W-1:0]      wr_idx;

  // Radix outside 2 to 36 is clamped to the nearest end.
  always_comb begin
    radix_cl = in_data.radix;
    if (in_data.radix < RADIX_MIN) begin
      radix_cl = RADIX_MIN;
    end else if (in_data.radix > RADIX_MAX) begin
      radix_cl = RADIX_MAX;
    end
  end

  assign in_bits = in_data.value;
  assign neg_dec = in_bits[VALUE_BITS-1] && (radix_cl == DEC_RADIX);
  assign mag     = neg_dec ? (~in_bits + 1'b1) : in_bits;

  // One restoring division step: shift the next dividend bit into the remainder.
  assign rem_sh   = {rem_r, quo_r[VALUE_BITS-1]};
  assign rem_ge   = rem_sh >= {1'b0, radix_r};
  assign rem_diff = rem_sh - {1'b0, radix_r};

  assign cnt_m1 = cnt_r - 1'b1;
  assign rd_idx = cnt_m1[IDX_W-1:0];
  assign wr_idx = cnt_r[IDX_W-1:0];

  always_comb begin
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load) begin
      quo_nxt = mag;
      rem_nxt = '0;
      cnt_nxt = '0;
    end
    if (cmd.div_step) begin
      quo_nxt = {quo_r[VALUE_BITS-2:0], rem_ge};
      rem_nxt = rem_ge ? rem_diff[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];
    end
    if (cmd.store) begin
      rem_nxt = '0;
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.emit_digit) begin
      cnt_nxt = cnt_m1;
    end
    if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (cmd.load) begin
      radix_r <= radix_cl;
      minus_r <= neg_dec;
    end
  end

  // Digits land least significant first and are read back in reverse.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      dig_mem[wr_idx] <= digit_char(rem_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_r.character <= CH_MINUS;
      out_r.last_char <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_r.character <= dig_mem[rd_idx];
      out_r.last_char <= (cnt_r == CNT_W'(1));
    end
  end

  assign stat.quo_zero   = (quo_r == '0);
  assign stat.minus      = minus_r;
  assign stat.out_free   = !out_valid_r || !out_stall;
  assign stat.last_digit = (cnt_r == CNT_W'(1));

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/integer_to_ascii_radix_core.sv
// Converts a signed 32-bit integer into its ASCII digit string in a radix from
// 2 to 36, most significant digit first, using '0'-'9' and then 'a'-'z'. Each
// character leaves as one transfer on the out_ channel, and the final
// character of a number carries last_char. In radix 10 a negative value is
// preceded by '-' and converted through its magnitude, so the most negative
// value converts exactly; in every other radix the value's bits are read as
// an unsigned number. Radix 0 and 1 act as 2, and 37 to 63 act as 36. Zero
// gives the single character '0', and no terminator is sent. One number is
// worked on at a time: in_stall is low only while the block is idle. Each
// digit is found by the shared one-bit-per-cycle restoring divider (32
// divide steps and then one store), and each character then leaves through
// the output register once that register is free. The output register lets
// the next number be accepted while the last character is still waiting to
// be taken.
module integer_to_ascii_radix_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  itoa_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output itoa_pkg::out_t  out_data
);
  import itoa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The controller sequences the divide, store and emit phases.
  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the divider, the digit buffer and the output register.
  itoa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Once a number is taken, the block stays busy while it is converted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a conversion was starting");

  // The controller never issues two datapath commands in one cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.div_step, cmd.store, cmd.emit_sign, cmd.emit_digit}))
    else $error("conflicting datapath commands");

  // A character is only written into the output register when it is free.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_sign || cmd.emit_digit) |-> stat.out_free)
    else $error("output register overwritten while stalled");

  // A minus sign is never the final character of a number.
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_sign |=> (out_valid && !out_data.last_char && out_data.character == CH_MINUS))
    else $error("minus sign flagged as last character");

endmodule

// File: test/itoa_string_checker.sv
`timescale 1ns / 100ps

// Watches both channels, predicts the character string of every number that
// goes in and compares each character that comes out against it, in order.
module itoa_string_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  itoa_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  itoa_pkg::out_t out_data,
  output int             fail_count,
  output int             pending,
  output int             chars_checked,
  output int             numbers_done
);
  import itoa_pkg::*;

  out_t expected_chars[$];
  int   errors = 0;
  int   chars = 0;
  int   numbers = 0;

  // Builds the expected characters of one number and queues them.
  task automatic predict_string(input in_t item);
    logic [VALUE_BITS-1:0] magnitude;
    logic [VALUE_BITS-1:0] digit;
    logic [RADIX_W-1:0]    base;
    logic [CHAR_W-1:0]     digits[$];
    logic                  minus;
    out_t                  ch;
    base = item.radix;
    if (base < RADIX_MIN) base = RADIX_MIN;
    if (base > RADIX_MAX) base = RADIX_MAX;
    minus = item.value[VALUE_BITS-1] && (base == DEC_RADIX);
    magnitude = item.value;
    if (minus) magnitude = ~magnitude + 1'b1;
    if (magnitude == '0) begin
      digits.push_front(CH_ZERO);
    end
    while (magnitude != '0) begin
      digit = magnitude % base;
      if (digit > MAX_DEC_DIGIT) begin
        digits.push_front(digit[CHAR_W-1:0] - DEC_RADIX + CH_A);
      end else begin
        digits.push_front(digit[CHAR_W-1:0] + CH_ZERO);
      end
      magnitude = magnitude / base;
    end
    if (minus) begin
      ch.character = CH_MINUS;
      ch.last_char = 1'b0;
      expected_chars.push_back(ch);
    end
    for (int i = 0; i < digits.size(); i++) begin
      ch.character = digits[i];
      ch.last_char = (i == digits.size() - 1);
      expected_chars.push_back(ch);
    end
  endtask

  always @(posedge clk) begin : watch_transfers
    out_t want;
    if (rst_n) begin
      // The outgoing character is matched before a new number is queued, so a
      // stray character can never pair with the number taken in at this edge.
      if (out_valid && !out_stall) begin
        chars++;
        if (out_data.last_char) numbers++;
        if (expected_chars.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected character %h (%c) last_char %b", $realtime,
                     out_data.character, out_data.character, out_data.last_char);
          end
        end else begin
          want = expected_chars.pop_front();
          if (out_data.character !== want.character ||
              out_data.last_char !== want.last_char) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: character mismatch: expected %h (%c) last %b, got %h (%c) last %b",
                       $realtime, want.character, want.character, want.last_char,
                       out_data.character, out_data.character, out_data.last_char);
            end
          end
        end
      end
      if (in_valid && !in_stall) predict_string(in_data);
    end
    fail_count    <= errors;
    pending       <= expected_chars.size();
    chars_checked <= chars;
    numbers_done  <= numbers;
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

// Top of the integer-to-string testbench. It drives numbers into the block,
// plays the character receiver, and gives the verdict. All checking of the
// characters is done by the checker instance that sits beside the block.
module tb_top;
  import itoa_pkg::*;

  localparam int RANDOM_ITEMS = 190;
  // The receiver's long hold-off, in cycles, which lets the block fill up.
  localparam int HOLD_CYCLES  = 400;
  // A 32-digit binary number is fully converted before its first
  // character leaves, so a stretch without any transfer this long means a hang.
  localparam int STALL_LIMIT  = 10000;
  localparam logic signed [VALUE_BITS-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [VALUE_BITS-1:0] MOST_POS = 32'sh7fff_ffff;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  int   fail_count;
  int   pending;
  int   chars_checked;
  int   numbers_done;
  int   accepted = 0;
  int   idle_cycles = 0;

  // Shared between the sender and the receiver. quiet switches off all random
  // idling on both sides; hold_request asks the receiver for its long hold.
  logic quiet = 1'b0;
  logic hold_request = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  integer_to_ascii_radix_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  itoa_string_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .chars_checked(chars_checked),
    .numbers_done (numbers_done)
  );

  function automatic in_t make_item(input logic signed [VALUE_BITS-1:0] v,
                                    input logic [RADIX_W-1:0] r);
    in_t item;
    item.value = v;
    item.radix = r;
    return item;
  endfunction

  // Random numbers lean toward the legal radixes and toward radix 10, where
  // the sign handling lives, while the full 0 to 63 range still shows up so
  // that the clamping at both ends is exercised. Values mix full-width
  // patterns, short magnitudes of both signs and the extremes.
  function automatic in_t random_item();
    logic signed [VALUE_BITS-1:0] v;
    logic [RADIX_W-1:0]           r;
    int                           pick;
    pick = $urandom_range(99);
    if (pick < 78) begin
      r = RADIX_W'($urandom_range(36, 2));
    end else if (pick < 88) begin
      r = DEC_RADIX;
    end else begin
      r = RADIX_W'($urandom_range(63, 0));
    end
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom;
      4, 5:       v = $urandom_range(1000);
      6:          v = 0 - $urandom_range(1000);
      7: begin
        case ($urandom_range(4))
          0:       v = '0;
          1:       v = MOST_NEG;
          2:       v = MOST_POS;
          3:       v = -1;
          default: v = 1;
        endcase
      end
      default: begin
        v = $urandom >> $urandom_range(31);
        if ($urandom_range(1)) v = 0 - v;
      end
    endcase
    return make_item(v, r);
  endfunction

  // Offers one number and returns at the falling edge after its transfer,
  // with in_valid still high so that a following number can take its place
  // without a gap.
  task automatic send_number(input in_t item);
    if (!quiet) begin
      while ($urandom_range(99) < 11) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    accepted++;
    @(negedge clk);
  endtask

  // Receiver. It stalls at random, except during the quiet stretch, and once
  // holds off for a long stretch so that the block backs up into its input.
  initial begin : receiver
    int held;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(99) < 11) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run if no transfer happens on either channel for too
  // long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[integer_to_ascii_radix_core] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed numbers: zero, the extremes, the sign in radix 10 only, the
    // boundary between decimal digits and letters, and clamped radixes.
    send_number(make_item(0, DEC_RADIX));
    send_number(make_item(0, RADIX_MIN));
    send_number(make_item(0, 6'd0));
    send_number(make_item(1, RADIX_MIN));
    send_number(make_item(-1, DEC_RADIX));
    send_number(make_item(-1, 6'd16));
    send_number(make_item(-1, RADIX_MIN));
    send_number(make_item(MOST_NEG, DEC_RADIX));
    send_number(make_item(MOST_NEG, RADIX_MIN));
    send_number(make_item(MOST_NEG, 6'd16));
    send_number(make_item(MOST_POS, DEC_RADIX));
    send_number(make_item(MOST_POS, RADIX_MAX));
    send_number(make_item(MOST_POS, RADIX_MIN));
    send_number(make_item(9, DEC_RADIX));
    send_number(make_item(10, 6'd11));
    send_number(make_item(35, RADIX_MAX));
    send_number(make_item(5, 6'd0));
    send_number(make_item(5, 6'd1));
    send_number(make_item(35, 6'd37));
    send_number(make_item(1295, 6'd63));
    send_number(make_item(-123, DEC_RADIX));
    send_number(make_item(-123, 6'd8));
    send_number(make_item(255, 6'd16));
    send_number(make_item(12345, 6'd7));

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 30) hold_request = 1'b1;
      quiet = (k >= 80 && k < 120);
      if (k == 150) begin
        // Let the block drain completely before going on.
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        @(negedge clk);
      end
      send_number(random_item());
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);

    $display("Sent %0d numbers and checked %0d characters of %0d strings, radix fields 0 to 63,",
             accepted, chars_checked, numbers_done);
    $display("with zero, signs, extremes, a long output hold-off and a full drain pause.");
    if (fail_count == 0 && pending == 0) begin
      $display("[integer_to_ascii_radix_core] OK");
    end else begin
      $display("[integer_to_ascii_radix_core] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/itoa_pkg.sv
rtl/itoa_ctrl.sv
rtl/itoa_dp.sv
rtl/integer_to_ascii_radix_core.sv
test/itoa_string_checker.sv
test/tb_top.sv
